/* hdl/ofsc_pkg.sv */
// Package for the open-file slot cache: beat structs, operation and status codes,
// sequencer states and fixed field widths.
// It has no dependencies.
`default_nettype none

package ofsc_pkg;

   localparam int OWNER_W  = 16;
   localparam int FILE_W   = 20;
   localparam int TIME_W   = 32;
   localparam int SLOT_W   = 5;
   localparam int COUNT_W  = 6;
   localparam int STATUS_W = 2;
   localparam int OP_W     = 2;

   typedef enum logic [OP_W-1:0] {
      OP_CHECKOUT    = 2'd0,
      OP_LOOKUP      = 2'd1,
      OP_CLOSE_FILE  = 2'd2,
      OP_CLOSE_OWNER = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_REFUSED   = 2'd1,
      STATUS_OPEN_FAIL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [OWNER_W-1:0] owner_id;
      logic [FILE_W-1:0]  file_number;
      logic               want_write;
      logic [TIME_W-1:0]  now_time;
      logic               open_ok;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic                was_hit;
      logic                need_open;
      logic                need_flush;
      logic                evicted;
      logic [OWNER_W-1:0]  evicted_owner;
      logic [FILE_W-1:0]   evicted_file;
      logic [COUNT_W-1:0]  closed_count;
   } rsp_type;

   typedef struct packed {
      logic [OWNER_W-1:0] owner;
      logic [FILE_W-1:0]  file;
      logic [TIME_W-1:0]  last_use;
   } entry_type;

   localparam int ENTRY_W = OWNER_W + FILE_W + TIME_W;

   typedef struct packed {
      logic hit_found;
      logic free_found;
      logic own_match;
   } scan_flags_type;

endpackage

`default_nettype wire

/* hdl/ofsc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// It has no dependencies.
`default_nettype none

module ofsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/ofsc_scan.sv */
// Shared slot compare unit: takes one slot entry per step and keeps the first hit,
// the first closed slot, the oldest slot and the owner match count. Uses ofsc_pkg.
`default_nettype none

module ofsc_scan #(
   parameter int SLOT_COUNT = 32,
   localparam int IW = $clog2(SLOT_COUNT),
   localparam int CW = $clog2(SLOT_COUNT + 1)
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic                               step,
   input  wire logic [IW-1:0]                      idx,
   input  wire ofsc_pkg::entry_type                entry,
   input  wire logic                               slot_is_open,
   input  wire logic [ofsc_pkg::OWNER_W-1:0]       key_owner,
   input  wire logic [ofsc_pkg::FILE_W-1:0]        key_file,
   output ofsc_pkg::scan_flags_type                flags,
   output logic      [IW-1:0]                      hit_idx,
   output logic      [IW-1:0]                      free_idx,
   output logic      [IW-1:0]                      min_idx,
   output ofsc_pkg::entry_type                     min_entry,
   output logic      [CW-1:0]                      own_count
);

   logic                hit_found_ff, hit_found_in;
   logic                free_found_ff, free_found_in;
   logic                min_vld_ff, min_vld_in;
   logic [CW-1:0]       own_count_ff, own_count_in;
   logic [IW-1:0]       hit_idx_ff, hit_idx_in;
   logic [IW-1:0]       free_idx_ff, free_idx_in;
   logic [IW-1:0]       min_idx_ff, min_idx_in;
   ofsc_pkg::entry_type min_entry_ff, min_entry_in;
   logic                owner_eq;
   logic                key_hit;
   logic                own_match;

   assign owner_eq  = entry.owner == key_owner;
   assign key_hit   = slot_is_open && owner_eq && (entry.file == key_file);
   assign own_match = step && slot_is_open && owner_eq;

   always_comb begin
      hit_found_in  = hit_found_ff;
      free_found_in = free_found_ff;
      min_vld_in    = min_vld_ff;
      own_count_in  = own_count_ff;
      hit_idx_in    = hit_idx_ff;
      free_idx_in   = free_idx_ff;
      min_idx_in    = min_idx_ff;
      min_entry_in  = min_entry_ff;
      if (start) begin
         hit_found_in  = 1'b0;
         free_found_in = 1'b0;
         min_vld_in    = 1'b0;
         own_count_in  = '0;
      end else if (step) begin
         if (key_hit && !hit_found_ff) begin
            hit_found_in = 1'b1;
            hit_idx_in   = idx;
         end
         if (!slot_is_open && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = idx;
         end
         if (!min_vld_ff || (entry.last_use < min_entry_ff.last_use)) begin
            min_vld_in   = 1'b1;
            min_idx_in   = idx;
            min_entry_in = entry;
         end
         if (own_match) begin
            own_count_in = own_count_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         min_vld_ff    <= 1'b0;
         own_count_ff  <= '0;
      end else begin
         hit_found_ff  <= hit_found_in;
         free_found_ff <= free_found_in;
         min_vld_ff    <= min_vld_in;
         own_count_ff  <= own_count_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_idx_ff   <= hit_idx_in;
      free_idx_ff  <= free_idx_in;
      min_idx_ff   <= min_idx_in;
      min_entry_ff <= min_entry_in;
   end

   assign flags.hit_found  = hit_found_ff;
   assign flags.free_found = free_found_ff;
   assign flags.own_match  = own_match;
   assign hit_idx          = hit_idx_ff;
   assign free_idx         = free_idx_ff;
   assign min_idx          = min_idx_ff;
   assign min_entry        = min_entry_ff;
   assign own_count        = own_count_ff;

endmodule

`default_nettype wire

/* hdl/open_file_slot_cache_lru_top.sv */
// Top level of the open-file slot cache: request sequencer, slot flags, result register.
// Depends on ofsc_pkg, ofsc_ram and ofsc_scan.
`default_nettype none

// A request beat is taken only while the sequencer is idle. It then reads every slot
// once through the key RAM, one slot per cycle, and the compare unit tracks the hit,
// the first closed slot, the oldest slot and the owner matches; a close-owner request
// clears each matching open slot as it is read. A decision step, which waits until the
// result register is free, then updates the chosen slot, if any, and loads the result
// register. A new request is taken while the last result beat still waits on rsp_stall,
// but its result is held back until that beat has left.
module open_file_slot_cache_lru_top #(
   parameter int SLOT_COUNT = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ofsc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ofsc_pkg::rsp_type      rsp_data
);

   localparam int IW = $clog2(SLOT_COUNT);
   localparam int CW = $clog2(SLOT_COUNT + 1);
   localparam int NW = IW + 1;
   localparam logic [NW-1:0] ADDR_END = NW'(SLOT_COUNT);
   localparam logic [IW-1:0] IDX_LAST = IW'(SLOT_COUNT - 1);

   ofsc_pkg::state_type state_ff, state_in;
   ofsc_pkg::req_type   req_ff, req_in;
   logic [NW-1:0]       addr_ff, addr_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [IW-1:0]       cmp_idx_ff, cmp_idx_in;
   logic [SLOT_COUNT-1:0] open_ff, open_in;
   logic [SLOT_COUNT-1:0] writable_ff, writable_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ofsc_pkg::rsp_type   rsp_ff, rsp_in;

   logic                     req_take;
   logic                     issue;
   logic                     scan_start;
   logic                     out_free;
   logic                     commit;
   logic                     ram_wr_en;
   logic [IW-1:0]            ram_wr_addr;
   logic [ofsc_pkg::ENTRY_W-1:0] ram_rd_data;
   ofsc_pkg::entry_type      ram_wr_entry;
   ofsc_pkg::entry_type      rd_entry;
   ofsc_pkg::scan_flags_type flags;
   logic [IW-1:0]            hit_idx;
   logic [IW-1:0]            free_idx;
   logic [IW-1:0]            min_idx;
   ofsc_pkg::entry_type      min_entry;
   logic [CW-1:0]            own_count;

   logic [IW-1:0]            sel_idx;
   logic                     slot_given;
   logic                     need_open;
   logic                     upd_write;
   logic                     upd_close;
   logic                     upd_open;
   ofsc_pkg::rsp_type        result;
   logic [IW+ofsc_pkg::SLOT_W-1:0]  slot_wide;
   logic [CW+ofsc_pkg::COUNT_W-1:0] count_wide;

   assign req_take   = req_valid && !req_stall;
   assign req_stall  = state_ff != ofsc_pkg::ST_IDLE;
   assign issue      = (state_ff == ofsc_pkg::ST_SCAN) && (addr_ff != ADDR_END);
   assign scan_start = req_take;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign commit     = (state_ff == ofsc_pkg::ST_DECIDE) && out_free;
   assign rd_entry   = ofsc_pkg::entry_type'(ram_rd_data);

   ofsc_ram #(
      .WIDTH (ofsc_pkg::ENTRY_W),
      .DEPTH (SLOT_COUNT)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (issue),
      .rd_addr (addr_ff[IW-1:0]),
      .rd_data (ram_rd_data)
   );

   ofsc_scan #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .start        (scan_start),
      .step         (cmp_vld_ff),
      .idx          (cmp_idx_ff),
      .entry        (rd_entry),
      .slot_is_open (open_ff[cmp_idx_ff]),
      .key_owner    (req_ff.owner_id),
      .key_file     (req_ff.file_number),
      .flags        (flags),
      .hit_idx      (hit_idx),
      .free_idx     (free_idx),
      .min_idx      (min_idx),
      .min_entry    (min_entry),
      .own_count    (own_count)
   );

   always_comb begin
      result     = '0;
      sel_idx    = '0;
      slot_given = 1'b0;
      need_open  = 1'b0;
      upd_write  = 1'b0;
      upd_close  = 1'b0;
      upd_open   = 1'b0;
      unique case (ofsc_pkg::op_type'(req_ff.operation))
         ofsc_pkg::OP_CHECKOUT: begin
            slot_given = 1'b1;
            if (flags.hit_found) begin
               sel_idx        = hit_idx;
               result.was_hit = 1'b1;
               need_open      = req_ff.want_write && !writable_ff[hit_idx];
            end else if (flags.free_found) begin
               sel_idx   = free_idx;
               need_open = 1'b1;
            end else begin
               sel_idx              = min_idx;
               need_open            = 1'b1;
               result.evicted       = 1'b1;
               result.evicted_owner = min_entry.owner;
               result.evicted_file  = min_entry.file;
            end
            result.need_open = need_open;
            if (need_open && !req_ff.open_ok) begin
               result.status = ofsc_pkg::STATUS_OPEN_FAIL;
               upd_close     = 1'b1;
            end else begin
               upd_open  = need_open;
               upd_write = 1'b1;
            end
         end
         ofsc_pkg::OP_LOOKUP: begin
            if (!flags.hit_found) begin
               result.status = ofsc_pkg::STATUS_REFUSED;
            end else begin
               sel_idx        = hit_idx;
               slot_given     = 1'b1;
               result.was_hit = 1'b1;
               if (req_ff.want_write && !writable_ff[hit_idx]) begin
                  result.status = ofsc_pkg::STATUS_REFUSED;
               end else begin
                  upd_write = 1'b1;
               end
            end
         end
         ofsc_pkg::OP_CLOSE_FILE: begin
            if (!flags.hit_found) begin
               result.status = ofsc_pkg::STATUS_REFUSED;
            end else begin
               sel_idx           = hit_idx;
               slot_given        = 1'b1;
               result.was_hit    = 1'b1;
               result.need_flush = writable_ff[hit_idx];
               upd_close         = 1'b1;
            end
         end
         ofsc_pkg::OP_CLOSE_OWNER: begin
            result.closed_count = count_wide[ofsc_pkg::COUNT_W-1:0];
         end
         default: begin
            result = '0;
         end
      endcase
      if (slot_given) begin
         result.slot = slot_wide[ofsc_pkg::SLOT_W-1:0];
      end
   end

   assign slot_wide  = {{ofsc_pkg::SLOT_W{1'b0}}, sel_idx};
   assign count_wide = {{ofsc_pkg::COUNT_W{1'b0}}, own_count};

   assign ram_wr_en             = commit && upd_write;
   assign ram_wr_addr           = sel_idx;
   assign ram_wr_entry.owner    = req_ff.owner_id;
   assign ram_wr_entry.file     = req_ff.file_number;
   assign ram_wr_entry.last_use = req_ff.now_time;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      addr_in      = addr_ff;
      cmp_vld_in   = issue;
      cmp_idx_in   = addr_ff[IW-1:0];
      open_in      = open_ff;
      writable_in  = writable_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ofsc_pkg::ST_IDLE: begin
            if (req_take) begin
               req_in   = req_data;
               addr_in  = '0;
               state_in = ofsc_pkg::ST_SCAN;
            end
         end
         ofsc_pkg::ST_SCAN: begin
            if (issue) begin
               addr_in = addr_ff + NW'(1);
            end
            if (flags.own_match &&
                (ofsc_pkg::op_type'(req_ff.operation) == ofsc_pkg::OP_CLOSE_OWNER)) begin
               open_in[cmp_idx_ff] = 1'b0;
            end
            if (cmp_vld_ff && (cmp_idx_ff == IDX_LAST)) begin
               state_in = ofsc_pkg::ST_DECIDE;
            end
         end
         ofsc_pkg::ST_DECIDE: begin
            if (commit) begin
               if (upd_close) begin
                  open_in[sel_idx] = 1'b0;
               end
               if (upd_open) begin
                  open_in[sel_idx]     = 1'b1;
                  writable_in[sel_idx] = req_ff.want_write;
               end
               rsp_valid_in = 1'b1;
               rsp_in       = result;
               state_in     = ofsc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ofsc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ofsc_pkg::ST_IDLE;
         addr_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         open_ff      <= '0;
         writable_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         cmp_vld_ff   <= cmp_vld_in;
         open_ff      <= open_in;
         writable_ff  <= writable_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      cmp_idx_ff <= cmp_idx_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_take_starts_scan : assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ofsc_pkg::ST_SCAN))
      else $error("accepted request beat did not start a slot scan");

   a_result_from_decide : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == ofsc_pkg::ST_DECIDE))
      else $error("result beat appeared outside the decision step");

   a_no_write_in_scan : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ofsc_pkg::ST_SCAN) |-> !ram_wr_en)
      else $error("key RAM written during a slot scan");

   a_reset_closes_slots : assert property (@(posedge clock)
      reset |=> (open_ff == '0) && !rsp_valid_ff)
      else $error("slots not all closed after reset");
`endif

endmodule

`default_nettype wire
